/* hdl/cmc_pkg.sv */
// ============================================================================
// cmc_pkg
// Shared types and command codes for the color matrix composer.
// ============================================================================
package cmc_pkg;

    // Command codes
    localparam logic [3:0] CMD_IDENTITY  = 4'd0;
    localparam logic [3:0] CMD_SCALE     = 4'd1;
    localparam logic [3:0] CMD_LUMA      = 4'd2;
    localparam logic [3:0] CMD_SATURATE  = 4'd3;
    localparam logic [3:0] CMD_XROT      = 4'd4;
    localparam logic [3:0] CMD_YROT      = 4'd5;
    localparam logic [3:0] CMD_ZROT      = 4'd6;
    localparam logic [3:0] CMD_ZSHEAR    = 4'd7;
    localparam logic [3:0] CMD_TRANSFORM = 4'd8;

    typedef struct packed {
        logic        [3:0]  command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic signed [31:0] operand_c;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } t_out_item;

    // One product issued to the shared MAC. tag is {row, col} or a plain index.
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [3:0] tag;
    } t_mac_issue;

    // Finished, saturated sum of products.
    typedef struct packed {
        logic               valid;
        logic        [3:0]  tag;
        logic signed [31:0] value;
    } t_mac_res;

endpackage

/* hdl/color_matrix_composer.sv */
// ============================================================================
// color_matrix_composer
// 3x3 color matrix composer: builds and composes matrices, transforms points.
// ============================================================================
// Holds a 3x3 color matrix in signed fixed point (FRAC_BITS fraction bits in
// 32 bits), reset to identity. Each input item is a command with three
// operands. Matrix commands (scale, luminance, saturate, x/y/z rotate,
// z shear) replace the matrix M by M x B and give no result; transform gives
// one result item, the row vector (a, b, c) times M. Load identity and the
// undefined codes 9..15 finish in the accept cycle. All products go through a
// single pipelined 32x32 multiply-accumulate unit (three stages), fed one
// product per cycle by a small sequencer, and the input side is not ready
// while an item is at work. After accept, transform issues 9 products,
// lets the pipeline drain and loads the output register; matrix commands
// issue 27 products and drain; saturate first issues 3 extra products to
// build its weights and lets them land, then issues the 27 and drains.
// A finished transform result sits in the output register; a following
// item is accepted while it waits, and only a second transform stalls, at
// its end, until the first is taken. Products are rounded half up at
// FRAC_BITS; sums and stored entries saturate to 32 signed bits.
// ============================================================================
module color_matrix_composer
    import cmc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // Fixed-point constants; luminance weights rounded to nearest.
    localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] LUM_R  =
        32'(((64'd3086 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [31:0] LUM_G  =
        32'(((64'd6094 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [31:0] LUM_B  =
        32'(((64'd820 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [33:0] S34_MAX = 34'sd2147483647;
    localparam logic signed [33:0] S34_MIN = -34'sd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,   // ready for an item
        ST_PREP,   // saturate: issue (1 - a) * L[k]
        ST_WAIT,   // saturate: let the weights land
        ST_MAC,    // issue the main products
        ST_DRAIN,  // wait for the MAC pipeline to empty
        ST_PUSH    // transform: move result to the output register
    } t_state;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > S34_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (v < S34_MIN) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    t_state             r_state;
    logic        [3:0]  r_cmd;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [31:0] r_c;
    logic signed [31:0] r_na;        // sat(-a)
    logic signed [31:0] r_inv;       // sat(1 - a)
    logic signed [31:0] r_p   [3];   // saturate weights (1 - a) * L[k]
    logic signed [31:0] r_m   [9];   // the color matrix, row-major
    logic signed [31:0] r_rowbuf [2];// finished row entries awaiting write-back
    logic        [1:0]  r_row;
    logic        [1:0]  r_col;
    logic        [1:0]  r_k;
    t_out_item          r_res;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               w_in_acc;
    logic signed [31:0] n_na;
    logic signed [31:0] n_inv;
    logic signed [31:0] w_vk;        // operand selected by k
    logic signed [31:0] w_lum;       // L[k]
    logic signed [31:0] w_bk;        // built entry B[k][col]
    logic signed [31:0] w_mrd;       // matrix read port
    logic        [3:0]  w_mrd_idx;
    logic        [3:0]  w_wr_base;
    t_mac_issue         w_issue;
    logic signed [31:0] w_op_a;
    logic signed [31:0] w_op_b;
    t_mac_res           w_res;
    logic               w_busy;
    logic               w_k_last;
    logic               w_col_last;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign n_na  = (i_in_item.operand_a == 32'sh8000_0000) ? 32'sh7FFF_FFFF
                                                           : -i_in_item.operand_a;
    assign n_inv = sat34(34'(FX_ONE) - 34'(i_in_item.operand_a));

    assign w_k_last   = (r_k == 2'd2);
    assign w_col_last = (r_col == 2'd2);

    // Operand and weight picked by the running k
    always_comb begin
        case (r_k)
            2'd0:    w_vk = r_a;
            2'd1:    w_vk = r_b;
            default: w_vk = r_c;
        endcase
        case (r_k)
            2'd0:    w_lum = LUM_R;
            2'd1:    w_lum = LUM_G;
            default: w_lum = LUM_B;
        endcase
    end

    // Built matrix entry B[k][col]
    always_comb begin
        w_bk = '0;
        unique case (r_cmd)
            CMD_SCALE: begin
                w_bk = (r_k == r_col) ? w_vk : '0;
            end
            CMD_LUMA: begin
                w_bk = w_lum;
            end
            CMD_SATURATE: begin
                w_bk = sat34(34'(r_p[r_k]) + ((r_k == r_col) ? 34'(r_a) : 34'sd0));
            end
            CMD_XROT: begin
                case ({r_k, r_col})
                    {2'd0, 2'd0}: w_bk = FX_ONE;
                    {2'd1, 2'd1}: w_bk = r_b;
                    {2'd1, 2'd2}: w_bk = r_a;
                    {2'd2, 2'd1}: w_bk = r_na;
                    {2'd2, 2'd2}: w_bk = r_b;
                    default:      w_bk = '0;
                endcase
            end
            CMD_YROT: begin
                case ({r_k, r_col})
                    {2'd0, 2'd0}: w_bk = r_b;
                    {2'd0, 2'd2}: w_bk = r_na;
                    {2'd1, 2'd1}: w_bk = FX_ONE;
                    {2'd2, 2'd0}: w_bk = r_a;
                    {2'd2, 2'd2}: w_bk = r_b;
                    default:      w_bk = '0;
                endcase
            end
            CMD_ZROT: begin
                case ({r_k, r_col})
                    {2'd0, 2'd0}: w_bk = r_b;
                    {2'd0, 2'd1}: w_bk = r_a;
                    {2'd1, 2'd0}: w_bk = r_na;
                    {2'd1, 2'd1}: w_bk = r_b;
                    {2'd2, 2'd2}: w_bk = FX_ONE;
                    default:      w_bk = '0;
                endcase
            end
            CMD_ZSHEAR: begin
                case ({r_k, r_col})
                    {2'd0, 2'd0}: w_bk = FX_ONE;
                    {2'd0, 2'd2}: w_bk = r_a;
                    {2'd1, 2'd1}: w_bk = FX_ONE;
                    {2'd1, 2'd2}: w_bk = r_b;
                    {2'd2, 2'd2}: w_bk = FX_ONE;
                    default:      w_bk = '0;
                endcase
            end
            default: begin
                w_bk = '0;
            end
        endcase
    end

    // Single matrix read port: M[row][k] for compose, M[k][col] for transform
    always_comb begin
        if (r_cmd == CMD_TRANSFORM) begin
            w_mrd_idx = 4'({2'b00, r_k} * 4'd3) + {2'b00, r_col};
        end else begin
            w_mrd_idx = 4'({2'b00, r_row} * 4'd3) + {2'b00, r_k};
        end
        w_mrd     = r_m[w_mrd_idx];
        w_wr_base = 4'({2'b00, w_res.tag[3:2]} * 4'd3);
    end

    // Product issue
    always_comb begin
        w_issue = '0;
        w_op_a  = w_mrd;
        w_op_b  = w_bk;
        if (r_state == ST_PREP) begin
            w_issue.valid = 1'b1;
            w_issue.first = 1'b1;
            w_issue.last  = 1'b1;
            w_issue.tag   = {2'b00, r_k};
            w_op_a        = r_inv;
            w_op_b        = w_lum;
        end else if (r_state == ST_MAC) begin
            w_issue.valid = 1'b1;
            w_issue.first = (r_k == 2'd0);
            w_issue.last  = w_k_last;
            if (r_cmd == CMD_TRANSFORM) begin
                w_issue.tag = {2'b00, r_col};
                w_op_a      = w_vk;
                w_op_b      = w_mrd;
            end else begin
                w_issue.tag = {r_row, r_col};
            end
        end
    end

    cmc_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (w_issue),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .o_res   (w_res),
        .o_busy  (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_k         <= '0;
            for (int e = 0; e < 9; e++) begin
                r_m[e] <= (e == 0 || e == 4 || e == 8) ? FX_ONE : '0;
            end
        end else begin
            // a push in the same cycle refills the output register below
            if (r_out_valid && i_out_ready && r_state != ST_PUSH) begin
                r_out_valid <= 1'b0;
            end

            // MAC results
            if (w_res.valid) begin
                if (r_state == ST_PREP || r_state == ST_WAIT) begin
                    r_p[w_res.tag[1:0]] <= w_res.value;
                end else if (r_cmd == CMD_TRANSFORM) begin
                    case (w_res.tag[1:0])
                        2'd0:    r_res.out_x <= w_res.value;
                        2'd1:    r_res.out_y <= w_res.value;
                        default: r_res.out_z <= w_res.value;
                    endcase
                end else if (w_res.tag[1:0] == 2'd2) begin
                    // row complete: write it back in one go
                    r_m[w_wr_base]        <= r_rowbuf[0];
                    r_m[w_wr_base + 4'd1] <= r_rowbuf[1];
                    r_m[w_wr_base + 4'd2] <= w_res.value;
                end else begin
                    r_rowbuf[w_res.tag[0]] <= w_res.value;
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd <= i_in_item.command;
                        r_a   <= i_in_item.operand_a;
                        r_b   <= i_in_item.operand_b;
                        r_c   <= i_in_item.operand_c;
                        r_na  <= n_na;
                        r_inv <= n_inv;
                        r_row <= '0;
                        r_col <= '0;
                        r_k   <= '0;
                        unique case (i_in_item.command)
                            CMD_IDENTITY: begin
                                for (int e = 0; e < 9; e++) begin
                                    r_m[e] <= (e == 0 || e == 4 || e == 8) ? FX_ONE : '0;
                                end
                            end
                            CMD_SATURATE: begin
                                r_state <= ST_PREP;
                            end
                            CMD_SCALE, CMD_LUMA, CMD_XROT, CMD_YROT, CMD_ZROT,
                            CMD_ZSHEAR, CMD_TRANSFORM: begin
                                r_state <= ST_MAC;
                            end
                            default: begin
                                // undefined code: dropped
                            end
                        endcase
                    end
                end
                ST_PREP: begin
                    if (w_k_last) begin
                        r_k     <= '0;
                        r_state <= ST_WAIT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                ST_WAIT: begin
                    if (!w_busy) begin
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (w_k_last) begin
                        r_k <= '0;
                        if (w_col_last) begin
                            r_col <= '0;
                            r_row <= r_row + 2'd1;
                            if (r_cmd == CMD_TRANSFORM || r_row == 2'd2) begin
                                r_state <= ST_DRAIN;
                            end
                        end else begin
                            r_col <= r_col + 2'd1;
                        end
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                ST_DRAIN: begin
                    if (!w_busy) begin
                        r_state <= (r_cmd == CMD_TRANSFORM) ? ST_PUSH : ST_IDLE;
                    end
                end
                ST_PUSH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= r_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/cmc_mac.sv */
// ============================================================================
// cmc_mac
// Shared pipelined fixed-point multiply-accumulate: product rounded half up,
// summed over a group, sum saturated to 32 signed bits.
// ============================================================================
module cmc_mac
    import cmc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_issue         i_issue,
    input  logic signed [31:0] i_op_a,
    input  logic signed [31:0] i_op_b,
    output t_mac_res           o_res,
    output logic               o_busy
);

    localparam int ACC_W = 66;
    localparam logic signed [63:0]    HALF    = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(64'sd2147483648);

    t_mac_issue               r_s1;
    t_mac_issue               r_s2;
    logic signed [31:0]       r_op_a;
    logic signed [31:0]       r_op_b;
    logic signed [63:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;
    logic [3:0]               r_done_tag;

    logic signed [63:0]       w_prod;
    logic signed [63:0]       w_rnd;
    logic signed [ACC_W-1:0]  n_acc;

    assign w_prod = $signed(r_op_a) * $signed(r_op_b);
    assign w_rnd  = r_prod >>> FRAC_BITS;
    assign n_acc  = (r_s2.first ? '0 : r_acc) + ACC_W'(w_rnd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= '0;
            r_s2   <= '0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_issue;
            r_s2   <= r_s1;
            r_done <= r_s2.valid && r_s2.last;
        end
        r_op_a     <= i_op_a;
        r_op_b     <= i_op_b;
        r_prod     <= w_prod + HALF;
        r_done_tag <= r_s2.tag;
        if (r_s2.valid) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        o_res.valid = r_done;
        o_res.tag   = r_done_tag;
        if (r_acc > ACC_MAX) begin
            o_res.value = 32'sh7FFF_FFFF;
        end else if (r_acc < ACC_MIN) begin
            o_res.value = 32'sh8000_0000;
        end else begin
            o_res.value = r_acc[31:0];
        end
    end

    assign o_busy = r_s1.valid || r_s2.valid || r_done;

endmodule

/* hdl/cmc_checker.sv */
// ============================================================================
// cmc_checker
// Port-level checks for the color matrix composer, bound to the top level.
// ============================================================================
module cmc_checker
    import cmc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // Out of reset: idle, nothing to deliver
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("not idle after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result dropped or changed while stalled");

    // A transform keeps the block busy after accept
    a_xform_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.command == CMD_TRANSFORM
        |=> !o_in_ready)
        else $error("transform accepted without going busy");

    // A new result only follows a busy cycle
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without work");

endmodule

bind color_matrix_composer cmc_checker u_cmc_checker (.*);

/* tb/color_matrix_composer_tb.sv */
// ============================================================================
// color_matrix_composer_tb
// Self-checking testbench for the 3x3 color matrix composer.
// ============================================================================
// The testbench keeps its own copy of the color matrix and updates it for
// every item that the block accepts. Matrix commands compose into that copy.
// Transform items queue the expected point, and the output monitor checks
// each returned item against that queue. Stimulus runs in this order: a short
// directed part (extremes, every command, overflow of the built entries,
// undefined codes), a part with random drains, a full-rate stretch, and long
// random traffic. Outside the full-rate stretch both sides idle at random.
// ============================================================================
module color_matrix_composer_tb;
    import cmc_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam longint FX_ONE  = longint'(1) << FRAC_BITS;
    localparam longint FX_HALF = longint'(1) << (FRAC_BITS - 1);
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // luminance weights, rounded to nearest at FRAC_BITS
    localparam longint LUM_R = ((longint'(3086) << FRAC_BITS) + 5000) / 10000;
    localparam longint LUM_G = ((longint'(6094) << FRAC_BITS) + 5000) / 10000;
    localparam longint LUM_B = ((longint'(820) << FRAC_BITS) + 5000) / 10000;

    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // operand spans for random matrix commands and random points
    localparam int MATRIX_SPAN = 2 << FRAC_BITS;
    localparam int POINT_SPAN  = 256 << FRAC_BITS;

    localparam int IDLE_PCT      = 35;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 1200;
    // Run limit in simulation time units; the slowest correct run of about 1200
    // items, with busy time, idle gaps and output stalls, ends well before it.
    localparam int RUN_LIMIT     = 1_000_000;

    logic      i_clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    t_in_item  in_item;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // shadow of the block's matrix, row-major
    longint    shadow_matrix[9];
    t_out_item pending_points[$];
    int        error_count;
    int        items_sent;
    bit        full_rate;

    color_matrix_composer #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed-point helpers for the shadow matrix
    // ------------------------------------------------------------------------
    function automatic longint sat32(longint v);
        if (v > S32_MAX) begin
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            return S32_MIN;
        end
        return v;
    endfunction

    // product rounded half up; the shift is arithmetic (floor)
    function automatic longint qmul(longint p, longint q);
        longint prod;
        prod = p * q + FX_HALF;
        return prod >>> FRAC_BITS;
    endfunction

    task automatic load_identity();
        for (int k = 0; k < 9; k++) begin
            shadow_matrix[k] = (k % 4 == 0) ? FX_ONE : 0;
        end
    endtask

    // Updates the shadow matrix for one accepted item; a transform queues
    // the point that the block must return.
    task automatic predict_item(input t_in_item item);
        longint    a, b, c, neg_a, inv;
        longint    built[9];
        longint    lum[3];
        longint    next[9];
        t_out_item pt;
        bit        compose;

        a     = longint'($signed(item.operand_a));
        b     = longint'($signed(item.operand_b));
        c     = longint'($signed(item.operand_c));
        neg_a = sat32(-a);       // -s of the most negative sine saturates
        lum   = '{LUM_R, LUM_G, LUM_B};
        for (int k = 0; k < 9; k++) begin
            built[k] = 0;
        end
        compose = 1'b1;

        case (item.command)
            CMD_IDENTITY: begin
                load_identity();
                compose = 1'b0;
            end
            CMD_SCALE: begin
                built[0] = a;
                built[4] = b;
                built[8] = c;
            end
            CMD_LUMA: begin
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        built[k * 3 + j] = lum[k];
                    end
                end
            end
            CMD_SATURATE: begin
                // 1 - a and each weight are formed wide, then saturated
                inv = sat32(FX_ONE - a);
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        built[k * 3 + j] = sat32(qmul(inv, lum[k]) + ((k == j) ? a : 0));
                    end
                end
            end
            CMD_XROT: begin
                built[0] = FX_ONE;
                built[4] = b;
                built[5] = a;
                built[7] = neg_a;
                built[8] = b;
            end
            CMD_YROT: begin
                built[0] = b;
                built[2] = neg_a;
                built[4] = FX_ONE;
                built[6] = a;
                built[8] = b;
            end
            CMD_ZROT: begin
                built[0] = b;
                built[1] = a;
                built[3] = neg_a;
                built[4] = b;
                built[8] = FX_ONE;
            end
            CMD_ZSHEAR: begin
                built[0] = FX_ONE;
                built[2] = a;
                built[4] = FX_ONE;
                built[5] = b;
                built[8] = FX_ONE;
            end
            CMD_TRANSFORM: begin
                // row vector (a, b, c) times the matrix
                pt.out_x = 32'(sat32(qmul(a, shadow_matrix[0]) + qmul(b, shadow_matrix[3])
                                   + qmul(c, shadow_matrix[6])));
                pt.out_y = 32'(sat32(qmul(a, shadow_matrix[1]) + qmul(b, shadow_matrix[4])
                                   + qmul(c, shadow_matrix[7])));
                pt.out_z = 32'(sat32(qmul(a, shadow_matrix[2]) + qmul(b, shadow_matrix[5])
                                   + qmul(c, shadow_matrix[8])));
                pending_points.push_back(pt);
                compose = 1'b0;
            end
            default: begin
                // undefined codes leave everything alone
                compose = 1'b0;
            end
        endcase

        if (compose) begin
            // M <= M x B, every sum saturated
            for (int r = 0; r < 3; r++) begin
                for (int col = 0; col < 3; col++) begin
                    next[r * 3 + col] = sat32(qmul(shadow_matrix[r * 3], built[col])
                                            + qmul(shadow_matrix[r * 3 + 1], built[3 + col])
                                            + qmul(shadow_matrix[r * 3 + 2], built[6 + col]));
                end
            end
            shadow_matrix = next;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item make_item(logic [3:0] cmd, logic signed [31:0] a,
                                           logic signed [31:0] b, logic signed [31:0] c);
        t_in_item item;
        item.command   = cmd;
        item.operand_a = a;
        item.operand_b = b;
        item.operand_c = c;
        return item;
    endfunction

    // Mostly values within +/- span, now and then an extreme or a full-range word.
    function automatic logic signed [31:0] pick_operand(int span);
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            case ($urandom_range(4))
                0: return Q_MIN;
                1: return Q_MAX;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return Q_ONE;
            endcase
        end
        if (roll < 20) begin
            return $urandom;
        end
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    // Valid stays high into the next item when no idle cycle is drawn.
    task automatic send_item(input t_in_item item);
        if (!full_rate) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_item(item);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Holds off the sender until every queued point is back, then lets a
    // matrix command that gives no result finish as well.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_points.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Usually: identity, a few random matrix commands, then a burst of
    // points. Otherwise one noise item with any code and any operands.
    task automatic send_random_sequence();
        int          n_cmds;
        int          n_points;
        logic [3:0]  cmd;
        t_in_item    noise;

        if ($urandom_range(99) < 15) begin
            noise.command   = 4'($urandom_range(15));
            noise.operand_a = $urandom;
            noise.operand_b = $urandom;
            noise.operand_c = $urandom;
            send_item(noise);
        end else begin
            if ($urandom_range(99) < 85) begin
                send_item(make_item(CMD_IDENTITY, $urandom, $urandom, $urandom));
            end
            n_cmds = $urandom_range(3);
            repeat (n_cmds) begin
                cmd = CMD_SCALE + 4'($urandom_range(CMD_ZSHEAR - CMD_SCALE));
                send_item(make_item(cmd, pick_operand(MATRIX_SPAN),
                                    pick_operand(MATRIX_SPAN), pick_operand(MATRIX_SPAN)));
            end
            n_points = $urandom_range(4, 1);
            repeat (n_points) begin
                send_item(make_item(CMD_TRANSFORM, pick_operand(POINT_SPAN),
                                    pick_operand(POINT_SPAN), pick_operand(POINT_SPAN)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Freshly reset matrix is identity; extreme points come back unchanged.
    task automatic test_reset_identity();
        send_item(make_item(CMD_TRANSFORM, Q_MAX, Q_MIN, 32'sd0));
        send_item(make_item(CMD_TRANSFORM, -32'sd1, 32'sd1, Q_MIN));
    endtask

    // Every matrix command but saturate once; transforms follow scale, luma and shear.
    task automatic test_each_command();
        send_item(make_item(CMD_SCALE, Q_MAX, Q_MIN, Q_ONE));
        send_item(make_item(CMD_TRANSFORM, Q_ONE, Q_ONE, Q_ONE));
        send_item(make_item(CMD_IDENTITY, Q_MAX, Q_MIN, -32'sd1));
        send_item(make_item(CMD_LUMA, 32'sd12345, -32'sd1, Q_MAX));
        send_item(make_item(CMD_TRANSFORM, 32'sd65536, 32'sd32768, -32'sd98304));
        send_item(make_item(CMD_IDENTITY, 32'sd0, 32'sd0, 32'sd0));
        // rotations about each axis with sine of magnitude 0.5, then a shear
        send_item(make_item(CMD_XROT, 32'sd32768, 32'sd56756, 32'sd777));
        send_item(make_item(CMD_YROT, -32'sd32768, 32'sd56756, 32'sd0));
        send_item(make_item(CMD_ZROT, 32'sd32768, -32'sd56756, Q_MIN));
        send_item(make_item(CMD_ZSHEAR, 32'sd16384, -32'sd16384, Q_MAX));
        send_item(make_item(CMD_TRANSFORM, 32'sd131072, -32'sd65536, 32'sd200000));
    endtask

    // Built entries that overflow 32 bits: 1 - a of the most negative
    // saturation, and -s of the most negative sine.
    task automatic test_built_overflow();
        send_item(make_item(CMD_IDENTITY, 32'sd0, 32'sd0, 32'sd0));
        send_item(make_item(CMD_SATURATE, Q_MIN, 32'sd5, 32'sd6));
        send_item(make_item(CMD_TRANSFORM, Q_ONE, -32'sd1, 32'sd3));
        send_item(make_item(CMD_IDENTITY, 32'sd0, 32'sd0, 32'sd0));
        send_item(make_item(CMD_XROT, Q_MIN, Q_ONE, 32'sd0));
        send_item(make_item(CMD_TRANSFORM, Q_ONE, Q_ONE, Q_ONE));
    endtask

    // Undefined codes change nothing and return nothing.
    task automatic test_undefined_codes();
        send_item(make_item(4'd9, Q_MIN, Q_MAX, Q_MIN));
        send_item(make_item(4'd15, Q_MAX, Q_MIN, Q_MAX));
        send_item(make_item(CMD_TRANSFORM, 32'sd70000, -32'sd70000, 32'sd1));
    endtask

    // Sender pauses until the block is fully idle between sequences.
    task automatic test_drain_pause();
        repeat (6) begin
            send_random_sequence();
            wait_drained();
        end
    endtask

    // Neither side idles: back-to-back items and results.
    task automatic test_full_rate();
        int stop_at;
        stop_at   = items_sent + 200;
        full_rate = 1'b1;
        while (items_sent < stop_at) begin
            send_random_sequence();
        end
        full_rate = 1'b0;
    endtask

    task automatic test_random_traffic();
        while (items_sent < RANDOM_ITEMS) begin
            send_random_sequence();
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random backpressure, and a check of every returned item
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        out_ready <= full_rate || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_points.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("unexpected result: x=%0d y=%0d z=%0d",
                             o_out_item.out_x, o_out_item.out_y, o_out_item.out_z);
                end
            end else begin
                want = pending_points.pop_front();
                if (want.out_x !== o_out_item.out_x || want.out_y !== o_out_item.out_y
                        || want.out_z !== o_out_item.out_z) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display({"point mismatch: expected x=%0d y=%0d z=%0d,",
                                  " got x=%0d y=%0d z=%0d"},
                                 want.out_x, want.out_y, want.out_z,
                                 o_out_item.out_x, o_out_item.out_y, o_out_item.out_z);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        error_count = 0;
        items_sent  = 0;
        full_rate   = 1'b0;
        load_identity();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_identity();
        test_each_command();
        test_built_overflow();
        test_undefined_codes();
        test_drain_pause();
        test_full_rate();
        test_random_traffic();
        wait_drained();

        if (error_count == 0 && pending_points.size() == 0) begin
            $display("color_matrix_composer test passed");
        end else begin
            $display("color_matrix_composer test failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("color_matrix_composer test failed");
        $finish;
    end

endmodule

/* files.f */
hdl/cmc_pkg.sv
hdl/cmc_mac.sv
hdl/color_matrix_composer.sv
hdl/cmc_checker.sv
tb/color_matrix_composer_tb.sv
